### design/pid_antiwindup_controller_top_defines.svh
// ----------------------------------------------------------------------------
// PID anti-windup controller - assertion macros
// Shared concurrent assertion forms. They use the including module's clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef PID_ANTIWINDUP_CONTROLLER_TOP_DEFINES_SVH
`define PID_ANTIWINDUP_CONTROLLER_TOP_DEFINES_SVH

// cons must hold in the same cycle as ante
`define PAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define PAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// PID anti-windup controller package
// Field widths, operation codes and register indexes.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int DT_W          = 31;
  localparam int INT_W         = 48;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int MUL_SPLIT     = 24;  // multiplier digit: 24 bits per pass

  localparam logic [OP_W-1:0] OP_STEP_CALC = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP_RATE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIM = 3'd5;

endpackage

### design/pid_antiwindup_controller_top.sv
// ----------------------------------------------------------------------------
// PID anti-windup controller
// Q.F fixed-point PID step with conditional integration and clamps.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A clear, or an unused operation,
// goes straight to the output state. A control step goes through one bit-serial
// multiplier that handles 24 multiplier bits per pass: each multiply is a load,
// a low pass and a high pass of 24 bits each, and a finish. It also uses one
// restoring divider at one quotient bit per cycle, 33+FRAC_BITS quotient bits per
// division. A step runs 5 to 7 multiplies and 0 to 2 divisions. Input is stalled
// while a step runs. The finished result sits in the output register, so the next
// step starts while the result waits to be taken.
`include "pid_antiwindup_controller_top_defines.svh"

module pid_antiwindup_controller_top import pidaw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [OP_W-1:0]             operation_i,
  input  logic signed [DATA_W-1:0]    measured_value_i,
  input  logic [DT_W-1:0]             time_step_i,
  input  logic signed [DATA_W-1:0]    given_rate_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_W-1:0]    drive_o,
  output logic                        limited_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]           cfg_data_i
);

  localparam int DVD_W = 33 + FRAC_BITS;
  localparam int DVS_W = 63 - FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int SHL   = MUL_SPLIT - FRAC_BITS;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_SPLIT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
  localparam logic [DATA_W-1:0] ONE_Q = 32'(1) << FRAC_BITS;
  localparam logic signed [57:0] LIM58 = 58'sd1 <<< 46;
  localparam logic signed [57:0] CAP58 = LIM58 >>> SHL;
  localparam logic signed [49:0] LIM50 = 50'sd1 <<< 46;
  localparam logic signed [47:0] I32MAX48 = 48'sh0000_7fff_ffff;
  localparam logic signed [47:0] I32MIN48 = -48'sh0000_8000_0000;
  localparam logic signed [63:0] I48MAX64 = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] I48MIN64 = -64'sh0000_8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_RATE, ST_MUL_GI, ST_MUL_GD, ST_MUL_GP,
    ST_MUL_ED, ST_MUL_PI, ST_DIV_BND, ST_OUT
  } state_e;

  typedef enum logic [1:0] {MP_LOAD, MP_LO, MP_HI, MP_FIN} mpass_e;

  state_e state_q;
  mpass_e mpass_q;
  logic [CNT_W-1:0] cnt_q;
  logic phase_q;  // 0: trial response, 1: final response
  logic out_valid_q;

  logic signed [DATA_W-1:0] gp_q, gi_q, gd_q, target_q, ol_q, il_q;
  logic signed [INT_W-1:0] integ_q;
  logic signed [DATA_W-1:0] prev_q;

  logic signed [DATA_W-1:0] err_q, rate_q;
  logic [DT_W-1:0] dt_q;
  logic signed [INT_W-1:0] t1_q, t2_q;
  logic signed [32:0] h_q;
  logic [MUL_SPLIT-1:0] l_q;
  logic signed [56:0] lo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] dvd_q;
  logic neg_q;
  logic signed [DATA_W-1:0] res_q, drive_q;
  logic res_lim_q, lim_q;

  // ---- input side ----
  logic in_acc;
  logic signed [32:0] err_ext, diff_ext;
  logic signed [DATA_W-1:0] err_w;
  logic [32:0] diff_abs;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign err_ext  = {target_q[31], target_q} - {measured_value_i[31], measured_value_i};
  assign err_w    = (err_ext[32] != err_ext[31]) ?
                    (err_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : err_ext[31:0];
  assign diff_ext = {measured_value_i[31], measured_value_i} - {prev_q[31], prev_q};
  assign diff_abs = diff_ext[32] ? 33'(-diff_ext) : 33'(diff_ext);

  // ---- multiplier operands ----
  logic signed [DATA_W-1:0] mul_a;
  logic signed [INT_W-1:0] mul_b, inner_w;
  logic signed [49:0] inner_s;
  logic is_mul;

  assign inner_s = {{18{err_q[31]}}, err_q} + {{2{t1_q[47]}}, t1_q}
                 - {{2{t2_q[47]}}, t2_q};
  assign inner_w = (inner_s > LIM50) ? 48'(LIM50) :
                   (inner_s < -LIM50) ? 48'(-LIM50) : inner_s[47:0];

  always_comb begin
    mul_a = gp_q;
    mul_b = '0;
    case (state_q)
      ST_MUL_GI: begin mul_a = gi_q;  mul_b = integ_q; end
      ST_MUL_GD: begin mul_a = gd_q;  mul_b = {{16{rate_q[31]}}, rate_q}; end
      ST_MUL_GP: begin mul_a = gp_q;  mul_b = inner_w; end
      ST_MUL_ED: begin mul_a = err_q; mul_b = {17'd0, dt_q}; end
      ST_MUL_PI: begin mul_a = gp_q;  mul_b = {{16{gi_q[31]}}, gi_q}; end
      default:   begin mul_a = gp_q;  mul_b = '0; end
    endcase
  end

  assign is_mul = (state_q == ST_MUL_GI) || (state_q == ST_MUL_GD) ||
                  (state_q == ST_MUL_GP) || (state_q == ST_MUL_ED) ||
                  (state_q == ST_MUL_PI);

  // ---- serial shift-add multiplier step ----
  logic mul_top;
  logic signed [33:0] a34, addend, t_w;
  assign mul_top = (mpass_q == MP_HI) && (cnt_q == MUL_LAST);  // sign digit of hi part
  assign a34     = {{2{mul_a[31]}}, mul_a};
  assign addend  = l_q[0] ? (mul_top ? -a34 : a34) : '0;
  assign t_w     = {h_q[32], h_q} + addend;

  // ---- product finish: scaled product with saturation, and raw product ----
  logic signed [56:0] prod_w, lo_sh;
  logic signed [57:0] prod58, hsh, sum58, mulq58;
  logic signed [47:0] mulq_w;
  logic signed [63:0] prod64, lo64, raw64, fs_w;

  assign prod_w = $signed({h_q, l_q});
  assign prod58 = {prod_w[56], prod_w};
  assign hsh    = prod58 <<< SHL;
  assign lo_sh  = lo_q >>> FRAC_BITS;
  assign sum58  = hsh + {lo_sh[56], lo_sh};
  assign mulq58 = (prod58 > CAP58) ? LIM58 :
                  (prod58 < -CAP58) ? -LIM58 :
                  (sum58 > LIM58) ? LIM58 :
                  (sum58 < -LIM58) ? -LIM58 : sum58;
  assign mulq_w = mulq58[47:0];
  assign prod64 = {{7{prod_w[56]}}, prod_w};
  assign lo64   = {{7{lo_q[56]}}, lo_q};
  assign raw64  = (prod64 <<< MUL_SPLIT) + lo64;
  assign fs_w   = raw64 >>> FRAC_BITS;

  // ---- response and anti-windup decisions ----
  logic signed [DATA_W-1:0] resp_w;
  logic [32:0] rmag, ol33;
  logic unwind, do_int, clamp_en, out_sat;
  logic signed [63:0] isum;
  logic signed [INT_W-1:0] isat;
  logic [63:0] kk_abs;

  assign resp_w   = (mulq_w > I32MAX48) ? 32'sh7fff_ffff :
                    (mulq_w < I32MIN48) ? 32'sh8000_0000 : mulq_w[31:0];
  assign rmag     = resp_w[31] ? 33'(-{resp_w[31], resp_w}) : {1'b0, resp_w};
  assign ol33     = {1'b0, ol_q};
  assign unwind   = (integ_q != '0) && (integ_q[47] != err_q[31]);
  assign do_int   = ol_q[31] || (rmag < ol33) || unwind;
  assign clamp_en = !il_q[31] && !gi_q[31] && (gi_q != '0);
  assign out_sat  = !ol_q[31] && (rmag >= ol33);
  assign isum     = {{16{integ_q[47]}}, integ_q} + fs_w;
  assign isat     = (isum > I48MAX64) ? I48MAX64[47:0] :
                    (isum < I48MIN64) ? I48MIN64[47:0] : isum[47:0];
  assign kk_abs   = fs_w[63] ? 64'(-fs_w) : 64'(fs_w);

  // ---- restoring divider step ----
  logic [DVS_W:0] r2, rsub;
  logic ge;
  logic [DVS_W-1:0] rem_d;
  logic [DVD_W-1:0] q_next;
  logic [63:0] q64;
  logic signed [DATA_W-1:0] rate_div;
  logic signed [INT_W-1:0] bnd;

  assign r2     = {rem_q, dvd_q[DVD_W-1]};
  assign rsub   = r2 - {1'b0, dvs_q};
  assign ge     = (r2 >= {1'b0, dvs_q});
  assign rem_d  = ge ? rsub[DVS_W-1:0] : r2[DVS_W-1:0];
  assign q_next = {dvd_q[DVD_W-2:0], ge};
  assign q64    = 64'(q_next);
  assign rate_div = neg_q ?
                    ((q64 > 64'h8000_0000) ? 32'sh8000_0000 : -q_next[31:0]) :
                    ((q64 > 64'h7fff_ffff) ? 32'sh7fff_ffff : q_next[31:0]);
  assign bnd    = (q64 > 64'h7fff_ffff_ffff) ? 48'sh7fff_ffff_ffff : 48'(q_next);

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mpass_q     <= MP_LOAD;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      gp_q        <= ONE_Q;
      gi_q        <= '0;
      gd_q        <= '0;
      target_q    <= '0;
      ol_q        <= -ONE_Q;
      il_q        <= -ONE_Q;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:  gp_q     <= cfg_data_i;
          CFG_GAIN_I:  gi_q     <= cfg_data_i;
          CFG_GAIN_D:  gd_q     <= cfg_data_i;
          CFG_TARGET:  target_q <= cfg_data_i;
          CFG_OUT_LIM: ol_q     <= cfg_data_i;
          CFG_INT_LIM: il_q     <= cfg_data_i;
          default: ;
        endcase
      end

      // in ST_OUT the output register is reloaded below instead
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      if (is_mul) begin
        case (mpass_q)
          MP_LOAD: begin
            h_q     <= '0;
            l_q     <= mul_b[MUL_SPLIT-1:0];
            cnt_q   <= '0;
            mpass_q <= MP_LO;
          end
          MP_LO: begin
            if (cnt_q == MUL_LAST) begin
              lo_q    <= $signed({t_w[33:1], t_w[0], l_q[MUL_SPLIT-1:1]});
              h_q     <= '0;
              l_q     <= mul_b[INT_W-1:MUL_SPLIT];
              cnt_q   <= '0;
              mpass_q <= MP_HI;
            end else begin
              h_q   <= t_w[33:1];
              l_q   <= {t_w[0], l_q[MUL_SPLIT-1:1]};
              cnt_q <= cnt_q + 1'b1;
            end
          end
          MP_HI: begin
            h_q   <= t_w[33:1];
            l_q   <= {t_w[0], l_q[MUL_SPLIT-1:1]};
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == MUL_LAST) begin
              mpass_q <= MP_FIN;
            end
          end
          default: begin
            mpass_q <= MP_LOAD;
          end
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            err_q   <= err_w;
            dt_q    <= time_step_i;
            phase_q <= 1'b0;
            case (operation_i)
              OP_STEP_CALC: begin
                prev_q <= measured_value_i;
                if (time_step_i == '0) begin
                  rate_q  <= '0;
                  state_q <= ST_MUL_GI;
                end else begin
                  neg_q   <= diff_ext[32];
                  dvd_q   <= {diff_abs, {FRAC_BITS{1'b0}}};
                  dvs_q   <= DVS_W'(time_step_i);
                  rem_q   <= '0;
                  cnt_q   <= '0;
                  state_q <= ST_DIV_RATE;
                end
              end
              OP_STEP_RATE: begin
                prev_q  <= measured_value_i;
                rate_q  <= given_rate_i;
                state_q <= ST_MUL_GI;
              end
              OP_CLEAR: begin
                integ_q   <= '0;
                prev_q    <= '0;
                res_q     <= '0;
                res_lim_q <= 1'b0;
                state_q   <= ST_OUT;
              end
              default: begin
                res_q     <= '0;
                res_lim_q <= 1'b0;
                state_q   <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV_RATE, ST_DIV_BND: begin
          rem_q <= rem_d;
          dvd_q <= q_next;
          if (cnt_q == DIV_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_MUL_GI;
            if (state_q == ST_DIV_RATE) begin
              rate_q <= rate_div;
            end else begin
              if (integ_q > bnd) begin
                integ_q <= bnd;
              end else if (integ_q < -bnd) begin
                integ_q <= -bnd;
              end
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL_GI: begin
          if (mpass_q == MP_FIN) begin
            t1_q    <= mulq_w;
            state_q <= phase_q ? ST_MUL_GP : ST_MUL_GD;
          end
        end
        ST_MUL_GD: begin
          if (mpass_q == MP_FIN) begin
            t2_q    <= mulq_w;
            state_q <= ST_MUL_GP;
          end
        end
        ST_MUL_GP: begin
          if (mpass_q == MP_FIN) begin
            if (!phase_q) begin
              // trial response decides whether the error is integrated
              if (do_int) begin
                state_q <= ST_MUL_ED;
              end else if (clamp_en) begin
                state_q <= ST_MUL_PI;
              end else begin
                phase_q <= 1'b1;
                state_q <= ST_MUL_GI;
              end
            end else begin
              res_q     <= out_sat ? (resp_w[31] ? -ol_q : ol_q) : resp_w;
              res_lim_q <= out_sat;
              state_q   <= ST_OUT;
            end
          end
        end
        ST_MUL_ED: begin
          if (mpass_q == MP_FIN) begin
            integ_q <= isat;
            if (clamp_en) begin
              state_q <= ST_MUL_PI;
            end else begin
              phase_q <= 1'b1;
              state_q <= ST_MUL_GI;
            end
          end
        end
        ST_MUL_PI: begin
          if (mpass_q == MP_FIN) begin
            phase_q <= 1'b1;
            if (fs_w != '0) begin
              neg_q   <= 1'b0;
              dvd_q   <= {2'b00, il_q[30:0], {FRAC_BITS{1'b0}}};
              dvs_q   <= kk_abs[DVS_W-1:0];
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_DIV_BND;
            end else begin
              state_q <= ST_MUL_GI;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            drive_q     <= res_q;
            lim_q       <= res_lim_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign limited_o   = lim_q;

  `PAW_ASSERT_NEXT(a_clear_state, in_acc && operation_i == OP_CLEAR, integ_q == '0 && prev_q == '0, "clear did not zero state")
  `PAW_ASSERT_NEXT(a_accept_busy, in_acc, state_q != ST_IDLE, "accepted transaction did not start")
  `PAW_ASSERT_NOW(a_mul_count, is_mul && (mpass_q == MP_LO || mpass_q == MP_HI), cnt_q <= MUL_LAST, "multiplier count overrun")
  `PAW_ASSERT_NOW(a_idle_mpass, state_q == ST_IDLE, mpass_q == MP_LOAD, "multiplier pass not reset")

endmodule

### tb/pid_antiwindup_controller_top_tb.sv
// ----------------------------------------------------------------------------
// PID anti-windup controller testbench
// Drives steps, clears and unused operations over several register settings,
// predicts each response in a Q16.16 model of its own and checks every output
// transaction in order, with random idling on both sides and one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pid_antiwindup_controller_top_tb;
  import pidaw_pkg::*;

  localparam int                    FRAC      = FRAC_BITS_DEF;
  localparam logic [OP_W-1:0]       OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_TOP = 3'd7;
  localparam longint WIDE_MAX = longint'(1) <<< 46;
  localparam longint I32_MAX  = 64'sh7FFFFFFF;
  localparam longint I32_MIN  = -64'sh80000000;
  localparam longint I48_MAX  = 64'sh7FFFFFFFFFFF;
  localparam longint I48_MIN  = -64'sh800000000000;
  localparam int     WATCHDOG_CYCLES = 20000;
  localparam int     HOLD_CYCLES     = 800;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] meas;
    logic [DT_W-1:0]          dt;
    logic signed [DATA_W-1:0] rate;
  } ctl_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
  } ctl_resp_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [OP_W-1:0]             operation_i;
  logic signed [DATA_W-1:0]    measured_value_i;
  logic [DT_W-1:0]             time_step_i;
  logic signed [DATA_W-1:0]    given_rate_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [DATA_W-1:0]    drive_o;
  logic                        limited_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [DATA_W-1:0]           cfg_data_i;

  pid_antiwindup_controller_top dut (.*);

  ctl_item_t pending_items[$];
  ctl_resp_t expected_resp[$];

  // controller model state
  longint kp, ki, kd, setpoint, out_lim, int_lim;
  longint integ_acc, prev_meas;

  int errors;
  int n_steps, n_limited, n_clears;
  int hold_req, hold_seen, hold_left;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // floor(a*b / 2^F) split over a 24-bit digit, saturated to +-2^46
  function automatic longint mul_q(longint a, longint b);
    longint bh, bl, hi, lo, cap;
    bh  = b >>> 24;
    bl  = b - (bh <<< 24);
    hi  = a * bh;
    lo  = a * bl;
    cap = WIDE_MAX >>> (24 - FRAC);
    if (hi > cap) return WIDE_MAX;
    if (hi < -cap) return -WIDE_MAX;
    return sat(hi * (longint'(1) <<< (24 - FRAC)) + (lo >>> FRAC), -WIDE_MAX, WIDE_MAX);
  endfunction

  function automatic longint response(longint err, longint integ, longint rate);
    longint inner;
    inner = sat(err + mul_q(ki, integ) - mul_q(kd, rate), -WIDE_MAX, WIDE_MAX);
    return sat(mul_q(kp, inner), I32_MIN, I32_MAX);
  endfunction

  function automatic ctl_resp_t predict_control(ctl_item_t it);
    ctl_resp_t r;
    longint meas, dt, err, rate, trial, mag, resp, kk, bound;
    bit unwind;
    r.drive   = '0;
    r.limited = 1'b0;
    if (it.op == OP_CLEAR) begin
      integ_acc = 0;
      prev_meas = 0;
      n_clears++;
      return r;
    end
    if (it.op == OP_UNUSED) return r;
    meas = longint'(it.meas);
    dt   = longint'({1'b0, it.dt});
    err  = sat(setpoint - meas, I32_MIN, I32_MAX);
    if (it.op == OP_STEP_RATE) rate = longint'(it.rate);
    else if (dt == 0) rate = 0;
    else rate = sat(((meas - prev_meas) <<< FRAC) / dt, I32_MIN, I32_MAX);
    prev_meas = meas;

    trial  = response(err, integ_acc, rate);
    mag    = (trial < 0) ? -trial : trial;
    unwind = (integ_acc != 0) && ((integ_acc < 0) != (err < 0));
    if (out_lim < 0 || mag < out_lim || unwind)
      integ_acc = sat(integ_acc + ((err * dt) >>> FRAC), I48_MIN, I48_MAX);

    if (int_lim >= 0 && ki > 0) begin
      kk = (kp * ki) >>> FRAC;
      if (kk != 0) begin
        if (kk < 0) kk = -kk;
        bound = sat((int_lim <<< FRAC) / kk, 0, I48_MAX);
        integ_acc = sat(integ_acc, -bound, bound);
      end
    end

    resp = response(err, integ_acc, rate);
    if (out_lim >= 0) begin
      mag = (resp < 0) ? -resp : resp;
      if (mag >= out_lim) begin
        resp = sat(resp, -out_lim, out_lim);
        r.limited = 1'b1;
      end
    end
    r.drive = resp[31:0];
    return r;
  endfunction

  // ---------------- driver ----------------
  ctl_item_t cur_item;
  int        send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    ctl_resp_t r;
    bit        nv;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      operation_i      <= OP_STEP_CALC;
      measured_value_i <= '0;
      time_step_i      <= '0;
      given_rate_i     <= '0;
      send_gap         = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        r = predict_control(cur_item);
        expected_resp.push_back(r);
        void'(pending_items.pop_front());
        send_gap = $urandom_range(0, 4);
      end
      if (!in_valid_i || !in_stall_o) begin
        nv = 1'b0;
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          nv               = 1'b1;
          cur_item         = pending_items[0];
          operation_i      <= cur_item.op;
          measured_value_i <= cur_item.meas;
          time_step_i      <= cur_item.dt;
          given_rate_i     <= cur_item.rate;
        end
        in_valid_i <= nv;
      end
    end
  end

  // ---------------- monitor ----------------
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    ctl_resp_t e;
    bit        st;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    = 0;
      hold_seen   = 0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resp.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction drive=%h limited=%b",
                   $time, drive_o, limited_o);
        end else begin
          e = expected_resp.pop_front();
          n_steps++;
          if (e.limited) n_limited++;
          if (drive_o !== e.drive) begin
            errors++;
            $display("%0t: drive mismatch expected %h actual %h", $time, e.drive, drive_o);
          end
          if (limited_o !== e.limited) begin
            errors++;
            $display("%0t: limited mismatch expected %b actual %b",
                     $time, e.limited, limited_o);
          end
        end
        recv_gap = $urandom_range(0, 4);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      st = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        st = 1'b1;
      end
      out_stall_i <= st;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired", $time);
      $display("pid_antiwindup_controller_top_tb failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    longint v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    v = longint'($signed(val));
    case (idx)
      CFG_GAIN_P:  kp       = v;
      CFG_GAIN_I:  ki       = v;
      CFG_GAIN_D:  kd       = v;
      CFG_TARGET:  setpoint = v;
      CFG_OUT_LIM: out_lim  = v;
      CFG_INT_LIM: int_lim  = v;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                          logic [31:0] t, logic [31:0] ol, logic [31:0] il);
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_TARGET, t);
    write_reg(CFG_OUT_LIM, ol);
    write_reg(CFG_INT_LIM, il);
    end_writes();
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_resp.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic push(logic [OP_W-1:0] op, logic [31:0] m, logic [30:0] dt,
                      logic [31:0] rt);
    ctl_item_t it;
    it.op = op; it.meas = m; it.dt = dt; it.rate = rt;
    pending_items.push_back(it);
  endtask

  // mostly modest Q16.16 values, sometimes full range or an extreme
  function automatic logic [31:0] rand_q(int span);
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 1) ? $urandom_range(0, span)
                                            : -$urandom_range(0, span);
    endcase
  endfunction

  function automatic logic [30:0] rand_dt();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'($urandom());
      2:       return 31'h7FFFFFFF;
      default: return 31'($urandom_range(1, 4 << FRAC));
    endcase
  endfunction

  task automatic random_items(int n, int span);
    int k;
    logic [OP_W-1:0] op;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0:       op = OP_CLEAR;
        1:       op = OP_UNUSED;
        2, 3, 4, 5, 6, 7: op = OP_STEP_RATE;
        default: op = OP_STEP_CALC;
      endcase
      push(op, rand_q(span), rand_dt(), rand_q(span));
    end
  endtask

  task automatic random_regs();
    set_regs(rand_q(4 << FRAC), rand_q(2 << FRAC), rand_q(1 << FRAC),
             rand_q(8 << FRAC), rand_q(16 << FRAC), rand_q(8 << FRAC));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_GAIN_P;
    cfg_data_i  = '0;
    errors = 0; n_steps = 0; n_limited = 0; n_clears = 0;
    hold_req = 0;
    kp = 65536; ki = 0; kd = 0; setpoint = 0; out_lim = -65536; int_lim = -65536;
    integ_acc = 0; prev_meas = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    random_items(60, 8 << FRAC);
    wait_idle();

    // directed: extremes, every operation, zero time step
    set_regs(32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
             32'h0003_0000, 32'h0001_0000);
    push(OP_STEP_CALC, 32'h0000_0000, 31'd0, 32'h0);
    push(OP_STEP_CALC, 32'h7FFF_FFFF, 31'd1, 32'h0);
    push(OP_STEP_CALC, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0);
    push(OP_STEP_CALC, 32'h8000_0000, 31'd0, 32'h0);
    push(OP_STEP_RATE, 32'h0001_0000, 31'h0001_0000, 32'h7FFF_FFFF);
    push(OP_STEP_RATE, 32'hFFFF_0000, 31'h0001_0000, 32'h8000_0000);
    push(OP_STEP_CALC, 32'h0005_0000, 31'h0001_0000, 32'h0);
    push(OP_STEP_CALC, 32'hFFFF_FFFF, 31'd1, 32'hFFFF_FFFF);
    push(OP_CLEAR, 32'h1234_5678, 31'h5555_5555, 32'hAAAA_AAAA);
    push(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    push(OP_STEP_CALC, 32'hFFF0_0000, 31'h0000_8000, 32'h0);
    push(OP_STEP_CALC, 32'hFFF0_0000, 31'h0004_0000, 32'h0);
    push(OP_STEP_CALC, 32'h0010_0000, 31'h0004_0000, 32'h0);
    push(OP_STEP_RATE, 32'h0001_0000, 31'd0, 32'h0000_0000);
    wait_idle();

    // negative proportional gain, tiny gain product, spare register index
    set_regs(32'hFFFE_0000, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000,
             32'h0000_0000, 32'h7FFF_FFFF);
    write_reg(CFG_SPARE, 32'hDEAD_BEEF);
    write_reg(CFG_SPARE_TOP, 32'h0);
    end_writes();
    random_items(100, 8 << FRAC);
    wait_idle();

    // extremes with the receiver held off to back up the input
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0000_0000);
    hold_req++;
    random_items(100, 32'h7FFF_FFFF);
    wait_idle();

    set_regs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000);
    random_items(80, 32'h7FFF_FFFF);
    wait_idle();

    repeat (4) begin
      random_regs();
      random_items(90, 8 << FRAC);
      wait_idle();
    end

    repeat (500) @(posedge clk_i);
    if (expected_resp.size() > 0) begin
      errors++;
      $display("%0t: %0d expected transactions never arrived", $time, expected_resp.size());
    end
    $display("Checked %0d responses (%0d clamped, %0d clears) over 9 register settings,",
             n_steps, n_limited, n_clears);
    $display("including clears, unused operations and a long output hold-off.");
    if (errors == 0) begin
      $display("pid_antiwindup_controller_top_tb passed");
    end else begin
      $display("pid_antiwindup_controller_top_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/pidaw_pkg.sv
design/pid_antiwindup_controller_top.sv
tb/pid_antiwindup_controller_top_tb.sv
